[rtl/core/rtb_pkg.sv]
// Package: types, constants and opcodes for the retransmit buffer.
`timescale 1ns / 1ps
package rtb_pkg;
  localparam int DepthDefault = 32;
  localparam logic [15:0] TimeoutReset = 16'd200;
  localparam logic [5:0] CapReset = 6'd32;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] KIND_PUSH    = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_RESEND  = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DUP = 2'd2;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_ENABLE  = 2'd1;
  localparam logic [1:0] REG_CAP     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EVAL, S_EMIT, S_SUM
  } state_t;

  typedef struct packed {
    logic load;      // capture input beat, clear scan
    logic rd;        // issue read at scan index
    logic eval;      // evaluate read entry, update table
    logic adv;       // advance scan index
    logic emit_sum;  // load summary / push status into output
    logic finish;    // commit ack compaction count, or store pushed entry
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       scan_done;
    logic       hit;       // entry produces a result beat
    logic       out_busy;
  } sts_t;
endpackage

[rtl/core/rtb_ctrl.sv]
// Controller state machine of the retransmit buffer.
`timescale 1ns / 1ps
module rtb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  rtb_pkg::sts_t sts,
  output rtb_pkg::cmd_t cmd
);
  import rtb_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid && !sts.out_busy) state_nxt = S_READ;
      S_READ: begin
        if (sts.op == OP_PUSH && sts.scan_done) state_nxt = S_SUM;
        else if (sts.op != OP_PUSH && sts.op != OP_ACK && sts.op != OP_TICK)
          state_nxt = S_IDLE;
        else if (sts.scan_done) state_nxt = S_SUM;
        else state_nxt = S_EVAL;
      end
      S_EVAL: state_nxt = sts.hit ? S_EMIT : S_READ;
      S_EMIT: if (!sts.out_busy) state_nxt = S_READ;
      S_SUM:  if (!sts.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = !sts.out_busy;
        cmd.load = in_tvalid && !sts.out_busy;
      end
      S_READ: cmd.rd = !sts.scan_done;
      S_EVAL: begin
        cmd.eval = 1'b1;
        cmd.adv = !sts.hit;
      end
      S_EMIT: cmd.adv = !sts.out_busy;
      S_SUM: begin
        cmd.emit_sum = !sts.out_busy;
        cmd.finish = !sts.out_busy;
      end
      default: ;
    endcase
  end
endmodule

[rtl/core/rtb_dp.sv]
// Datapath of the retransmit buffer: entry table, scan, output register.
`timescale 1ns / 1ps
module rtb_dp #(
  parameter int DEPTH = rtb_pkg::DepthDefault
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rtb_pkg::cmd_t cmd,
  output rtb_pkg::sts_t sts,
  input  logic [97:0]   in_data,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [87:0]   out_data,
  output logic [1:0]    out_kind,
  output logic          out_last
);
  import rtb_pkg::*;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 104;  // seq, handle, length, time, tries

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_r;

  logic [15:0] tmo_r;
  logic        en_r;
  logic [5:0]  cap_r;
  logic [CW-1:0] cnt_r, idx_r, kept_r, n_r;
  logic [1:0]  op_r;
  logic [31:0] seq_r, now_r;
  logic [15:0] hdl_r, len_r;
  logic        dup_r;
  logic        ov_r;
  logic [111:0] od_r;
  logic [1:0]  ok_r;
  logic        ol_r;

  logic [31:0] e_seq, e_time;
  logic [15:0] e_hdl, e_len;
  logic [7:0]  e_tries;
  logic        hit;
  logic [CW-1:0] cap_eff;
  logic        full;

  assign {e_tries, e_time, e_len, e_hdl, e_seq} = rd_r;
  assign cap_eff = ({1'b0, cap_r} < 7'(DEPTH)) ? CW'(cap_r) : CW'(DEPTH);
  assign full = cnt_r >= cap_eff;

  always_comb begin
    logic [31:0] d;
    hit = 1'b0;
    d = seq_r - e_seq;
    if (op_r == OP_ACK) hit = !d[31];
    else if (op_r == OP_TICK) hit = en_r && ((now_r - e_time) > {16'd0, tmo_r});
  end

  assign sts.op = op_r;
  assign sts.scan_done = (op_r == OP_PUSH) ? (full || idx_r >= cnt_r) : (idx_r >= cnt_r);
  assign sts.hit = hit;
  assign sts.out_busy = ov_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= TimeoutReset; en_r <= 1'b1; cap_r <= CapReset;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_TIMEOUT) tmo_r <= cfg_data;
      else if (cfg_index == REG_ENABLE) en_r <= cfg_data[0];
      else if (cfg_index == REG_CAP) cap_r <= cfg_data[5:0];
    end
  end

  // table and scan
  always_ff @(posedge clk) begin
    if (cmd.rd) rd_r <= mem[idx_r[AW-1:0]];
    if (cmd.eval) begin
      if (op_r == OP_ACK && !hit) mem[kept_r[AW-1:0]] <= rd_r;
      if (op_r == OP_TICK && hit)
        mem[idx_r[AW-1:0]] <= {(e_tries == 8'hFF) ? e_tries : e_tries + 8'd1,
                               now_r, e_len, e_hdl, e_seq};
    end
    if (cmd.finish && op_r == OP_PUSH && !full && !dup_r)
      mem[cnt_r[AW-1:0]] <= {8'd0, now_r, len_r, hdl_r, seq_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; idx_r <= '0; kept_r <= '0; n_r <= '0; op_r <= OP_PUSH; dup_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        {now_r, len_r, hdl_r, seq_r, op_r} <= in_data;
        idx_r <= '0; kept_r <= '0; n_r <= '0; dup_r <= 1'b0;
      end
      if (cmd.eval) begin
        if (op_r == OP_PUSH && e_seq == seq_r) dup_r <= 1'b1;
        if (op_r == OP_ACK && !hit) kept_r <= kept_r + 1'b1;
        if (hit) n_r <= n_r + 1'b1;
      end
      if (cmd.adv) idx_r <= idx_r + 1'b1;
      if (cmd.finish) begin
        if (op_r == OP_ACK) cnt_r <= kept_r;
        else if (op_r == OP_PUSH && !full && !dup_r) cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // output register: seq, handle, length, tries, status, count
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.eval && hit) ov_r <= 1'b1;
    else if (cmd.emit_sum) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
    if (cmd.eval && hit) begin
      ol_r <= 1'b0;
      if (op_r == OP_ACK) begin
        ok_r <= KIND_RELEASE; od_r <= {6'd0, 2'd0, 8'd0, 16'd0, e_hdl, e_seq, 32'd0};
      end else begin
        ok_r <= KIND_RESEND; od_r <= {6'd0, 2'd0, e_tries, e_len, e_hdl, e_seq, 32'd0};
      end
    end else if (cmd.emit_sum) begin
      ol_r <= 1'b1;
      if (op_r == OP_PUSH) begin
        ok_r <= KIND_PUSH;
        od_r <= {6'd0, full ? ST_OVF : (dup_r ? ST_DUP : ST_OK), 8'd0, len_r, hdl_r,
                 seq_r, 32'd0};
      end else begin
        ok_r <= KIND_SUMMARY; od_r <= {6'(n_r), 2'd0, 8'd0, 16'd0, 16'd0, 32'd0, 32'd0};
      end
    end
  end

  assign out_tvalid = ov_r;
  // reorder to tdata: status, seq, handle, length, tries, count
  assign out_data = {8'd0, od_r[111:106], od_r[103:96], od_r[95:80], od_r[79:64],
                     od_r[63:32], od_r[105:104]};
  assign out_kind = ok_r;
  assign out_last = ol_r;
endmodule

[rtl/core/retransmit_buffer.sv]
// Top level of the retransmit buffer.
// Push: duplicate scan over stored entries, each read then compared; no scan when full.
// Ack and tick: each stored entry is read then evaluated; a hit emits a result beat, and output stalls hold the scan.
// Up to DEPTH + 1 (33) result beats per item; one item in flight at a time.
// Output register decouples result stalls; rst_n clears count and restores config defaults.
// Table contents are undefined after reset; only entries below count are read.
`timescale 1ns / 1ps
module retransmit_buffer #(
  parameter int DEPTH = rtb_pkg::DepthDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode, seq_num, buffer_handle, buffer_length, now_ms, pad
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, out_seq_num, out_handle, out_length, tries, affected_count, pad
  output logic [87:0]  out_tdata,
  output logic [1:0]   out_tuser,  // result_kind
  output logic         out_tlast,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import rtb_pkg::*;
  cmd_t cmd;
  sts_t sts;

  rtb_ctrl u_ctrl (.clk, .rst_n, .in_tvalid, .in_tready, .sts, .cmd);

  rtb_dp #(.DEPTH(DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_data({in_tdata[97:66], in_tdata[65:50], in_tdata[49:34], in_tdata[33:2],
              in_tdata[1:0]}),
    .cfg_wr_en, .cfg_index, .cfg_data,
    .out_tvalid, .out_tready, .out_data(out_tdata), .out_kind(out_tuser),
    .out_last(out_tlast)
  );

  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tuser != KIND_PUSH |-> out_tuser == KIND_SUMMARY)
    else $error("final beat of ack/tick is not a summary");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(out_tvalid && !out_tready))
    else $error("input taken while output stalled");
endmodule

[tb/tb_retransmit_buffer.sv]
// Self-checking testbench for the retransmit buffer: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_retransmit_buffer;
  import rtb_pkg::*;

  localparam int DEPTH = DepthDefault;
  localparam int NUM_RANDOM = 200;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] seq;
    logic [15:0] handle;
    logic [15:0] length;
    logic [7:0]  tries;
    logic [5:0]  count;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] seq;
    logic [15:0] handle;
    logic [15:0] length;
    logic [31:0] now;
    logic        chk;     // typed-in expectation applies
    logic [1:0]  exp_kind;
    logic [1:0]  exp_status;
  } row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [103:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [87:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  retransmit_buffer #(.DEPTH(DEPTH)) uut (.*);

  // shadow table
  logic [31:0] tbl_seq [DEPTH];
  logic [15:0] tbl_hdl [DEPTH];
  logic [15:0] tbl_len [DEPTH];
  logic [31:0] tbl_time [DEPTH];
  logic [7:0]  tbl_tries [DEPTH];
  int tbl_count;
  logic [15:0] timeout_ms;
  logic enable;
  logic [5:0] cap;

  beat_t pending_beats[$];
  int errors, mismatches, cycles;
  logic drain_stall;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic beat_t mk(logic [1:0] k, logic [1:0] s, logic [31:0] q,
                               logic [15:0] h, logic [15:0] l, logic [7:0] t,
                               logic [5:0] c, logic lst);
    beat_t b;
    b.kind = k; b.status = s; b.seq = q; b.handle = h; b.length = l;
    b.tries = t; b.count = c; b.last = lst;
    return b;
  endfunction

  task automatic predict_item(input row_t r);
    int eff, kept, n;
    logic [1:0] st;
    if (r.op == OP_PUSH) begin
      eff = (cap < DEPTH) ? cap : DEPTH;
      st = ST_OK;
      if (tbl_count >= eff) st = ST_OVF;
      else for (int i = 0; i < tbl_count; i++) if (tbl_seq[i] == r.seq) st = ST_DUP;
      if (st == ST_OK) begin
        tbl_seq[tbl_count] = r.seq; tbl_hdl[tbl_count] = r.handle;
        tbl_len[tbl_count] = r.length; tbl_time[tbl_count] = r.now;
        tbl_tries[tbl_count] = 0; tbl_count++;
      end
      pending_beats.push_back(mk(KIND_PUSH, st, r.seq, r.handle, r.length, 0, 0, 1));
    end else if (r.op == OP_ACK) begin
      kept = 0; n = 0;
      for (int i = 0; i < tbl_count; i++) begin
        if ((r.seq - tbl_seq[i]) < 32'h8000_0000) begin
          pending_beats.push_back(mk(KIND_RELEASE, ST_OK, tbl_seq[i], tbl_hdl[i], 0, 0, 0, 0));
          n++;
        end else begin
          tbl_seq[kept] = tbl_seq[i]; tbl_hdl[kept] = tbl_hdl[i];
          tbl_len[kept] = tbl_len[i]; tbl_time[kept] = tbl_time[i];
          tbl_tries[kept] = tbl_tries[i]; kept++;
        end
      end
      tbl_count = kept;
      pending_beats.push_back(mk(KIND_SUMMARY, ST_OK, 0, 0, 0, 0, n[5:0], 1));
    end else if (r.op == OP_TICK) begin
      n = 0;
      if (enable) for (int i = 0; i < tbl_count; i++) begin
        if ((r.now - tbl_time[i]) > {16'd0, timeout_ms}) begin
          pending_beats.push_back(mk(KIND_RESEND, ST_OK, tbl_seq[i], tbl_hdl[i],
                                     tbl_len[i], tbl_tries[i], 0, 0));
          tbl_time[i] = r.now;
          if (tbl_tries[i] != 8'hFF) tbl_tries[i]++;
          n++;
        end
      end
      pending_beats.push_back(mk(KIND_SUMMARY, ST_OK, 0, 0, 0, 0, n[5:0], 1));
    end
  endtask

  // output side: random stalls and checking
  initial begin
    int w;
    beat_t got, want;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      w = drain_stall ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
      if ($urandom_range(0, 4) == 0) w = 0;
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk iff out_tvalid);
      got = mk(out_tuser, out_tdata[1:0], out_tdata[33:2], out_tdata[49:34],
               out_tdata[65:50], out_tdata[73:66], out_tdata[79:74], out_tlast);
      if (pending_beats.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected beat %h", got);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches++ < 10) $display("mismatch exp %h got %h", want, got);
        end
      end
    end
  end

  task automatic send(input row_t r);
    int w;
    w = $urandom_range(0, 9);
    if (w > 0) begin
      in_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    in_tdata <= {6'd0, r.now, r.length, r.handle, r.seq, r.op};
    in_tvalid <= 1;
    @(posedge clk iff in_tready);
    predict_item(r);
    if (r.chk && (pending_beats[$].kind !== r.exp_kind ||
                  pending_beats[$].status !== r.exp_status)) begin
      errors++;
      if (mismatches++ < 10)
        $display("directed exp kind %0d status %0d got kind %0d status %0d",
                 r.exp_kind, r.exp_status, pending_beats[$].kind, pending_beats[$].status);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    in_tvalid <= 0;
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    @(posedge clk);
    if (idx == REG_TIMEOUT) timeout_ms = val;
    else if (idx == REG_ENABLE) enable = val[0];
    else if (idx == REG_CAP) cap = val[5:0];
  endtask

  function automatic row_t rw(logic [1:0] op, logic [31:0] q, logic [15:0] h,
                              logic [15:0] l, logic [31:0] t, logic c, logic [1:0] s);
    row_t r;
    r.op = op; r.seq = q; r.handle = h; r.length = l; r.now = t;
    r.chk = c; r.exp_kind = KIND_PUSH; r.exp_status = s;
    return r;
  endfunction

  row_t directed[$];
  row_t r;
  logic [31:0] clock_ms, base_seq;

  initial begin
    errors = 0; mismatches = 0; drain_stall = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    cfg_wr_en = 0; cfg_index = '0; cfg_data = '0;
    tbl_count = 0; timeout_ms = TimeoutReset; enable = 1; cap = CapReset;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    directed = '{
      rw(OP_TICK, 0, 0, 0, 0, 0, 0),
      rw(OP_ACK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0),
      rw(OP_PUSH, 0, 0, 0, 0, 1, ST_OK),
      rw(OP_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, ST_OK),
      rw(OP_PUSH, 0, 16'h1234, 16'h55, 5, 1, ST_DUP),
      rw(OP_PUSH, 32'h8000_0000, 16'hAAAA, 16'h5555, 32'd10, 1, ST_OK),
      rw(OP_TICK, 0, 0, 0, 32'd200, 0, 0),
      rw(OP_TICK, 0, 0, 0, 32'd201, 0, 0),
      rw(OP_TICK, 0, 0, 0, 32'h0000_0500, 0, 0),
      rw(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 0),
      rw(OP_ACK, 0, 0, 0, 0, 0, 0),          // 2^31 apart is kept
      rw(OP_ACK, 32'h8000_0000, 0, 0, 0, 0, 0),
      rw(OP_ACK, 32'h7FFF_FFFF, 0, 0, 0, 0, 0)
    };
    foreach (directed[i]) send(directed[i]);
    wait_idle();

    // tries saturation, timeout extreme low
    write_reg(REG_TIMEOUT, 16'd1);
    send(rw(OP_PUSH, 32'd77, 16'd7, 16'd70, 32'd0, 1, ST_OK));
    for (int i = 1; i <= 260; i++) send(rw(OP_TICK, 0, 0, 0, 32'(i * 2), 0, 0));
    send(rw(OP_ACK, 32'd100, 0, 0, 0, 0, 0));
    wait_idle();

    // capacity extremes and disabled resend
    write_reg(REG_CAP, 16'd0);
    send(rw(OP_PUSH, 32'd1, 16'd1, 16'd1, 0, 1, ST_OVF));
    wait_idle();
    write_reg(REG_CAP, 16'd63);
    write_reg(REG_ENABLE, 16'd0);
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h0001);
    for (int i = 0; i < 33; i++) send(rw(OP_PUSH, 32'(i + 500), 16'(i), 16'(i), 0, 0, 0));
    send(rw(OP_TICK, 0, 0, 0, 32'h8000_0000, 0, 0));
    wait_idle();
    write_reg(REG_ENABLE, 16'd1);
    send(rw(OP_TICK, 0, 0, 0, 32'h8000_0000, 0, 0));
    send(rw(OP_ACK, 32'd600, 0, 0, 0, 0, 0));
    wait_idle();

    clock_ms = $urandom; base_seq = $urandom;
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_TIMEOUT, (ph == 0) ? 16'hFFFF : 16'($urandom_range(1, 60)));
      write_reg(REG_ENABLE, (ph == 3) ? 16'd0 : 16'd1);
      write_reg(REG_CAP, (ph == 1) ? 16'd1 : 16'($urandom_range(2, 40)));
      for (int i = 0; i < NUM_RANDOM / 5; i++) begin
        clock_ms += $urandom_range(0, 40);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            r = rw(OP_PUSH, base_seq + $urandom_range(0, 40), 16'($urandom),
                   16'($urandom), clock_ms, 0, 0);
          end
          4, 5: r = rw(OP_ACK, base_seq + $urandom_range(0, 30), 16'($urandom),
                       16'($urandom), $urandom, 0, 0);
          6, 7, 8: r = rw(OP_TICK, $urandom, 16'($urandom), 16'($urandom), clock_ms, 0, 0);
          default: r = rw(2'($urandom_range(0, 3)), $urandom, 16'($urandom), 16'($urandom),
                          $urandom, 0, 0);
        endcase
        if ($urandom_range(0, 15) == 0) base_seq += $urandom_range(1, 20);
        send(r);
        if (i == 20) wait_idle();
      end
      wait_idle();
    end

    drain_stall = 1;
    wait_idle();
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
